[sv/stereo_peak_limiter_top_macros.svh]
// ----------------------------------------------------------------------------
// stereo_peak_limiter_top_macros
// assertion macros for the stereo peak limiter
// ----------------------------------------------------------------------------
`ifndef STEREO_PEAK_LIMITER_TOP_MACROS_SVH
`define STEREO_PEAK_LIMITER_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SPL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stereo peak limiter: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define SPL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stereo peak limiter: next-cycle check failed");

`endif

[sv/spl_pkg.sv]
// ----------------------------------------------------------------------------
// spl_pkg
// shared types and constants of the stereo peak limiter
// ----------------------------------------------------------------------------
`default_nettype none

package spl_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_LIMIT_POS   = 3'd0;
    localparam logic [2:0] CFG_LIMIT_NEG   = 3'd1;
    localparam logic [2:0] CFG_ENV_TARGET  = 3'd2;
    localparam logic [2:0] CFG_HOLD        = 3'd3;
    localparam logic [2:0] CFG_MAKEUP_GAIN = 3'd4;

    // reset values of the configuration registers
    localparam logic [14:0]        RST_LIMIT_POS   = 15'd32767;
    localparam logic signed [15:0] RST_LIMIT_NEG   = -16'sd32768;
    localparam logic [6:0]         RST_ENV_TARGET  = 7'd100;
    localparam logic [15:0]        RST_HOLD        = 16'd9600;
    localparam logic [15:0]        RST_MAKEUP_GAIN = 16'd4096;

    // datapath step codes
    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_ENV  = 3'd1,
        OP_MAG  = 3'd2,
        OP_REC  = 3'd3,
        OP_FIX  = 3'd4,
        OP_SGN  = 3'd5,
        OP_GAIN = 3'd6,
        OP_SAT  = 3'd7
    } t_op;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        t_op  op;
        logic ch;
        logic load_out;
    } t_cmd;

    // configuration register contents
    typedef struct packed {
        logic [14:0]        limit_pos;
        logic signed [15:0] limit_neg;
        logic [6:0]         envelope_target;
        logic [15:0]        hold_samples;
        logic [15:0]        makeup_gain;
    } t_cfg;

endpackage

`default_nettype wire

[sv/spl_in_if.sv]
// ----------------------------------------------------------------------------
// spl_in_if
// input channel: one stereo sample pair per item
// ----------------------------------------------------------------------------
`default_nettype none

interface spl_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;
    logic               frame_end;

    modport source (output valid, output left_in, output right_in, output frame_end,
                    input ready);
    modport sink   (input valid, input left_in, input right_in, input frame_end,
                    output ready);
endinterface

`default_nettype wire

[sv/spl_out_if.sv]
// ----------------------------------------------------------------------------
// spl_out_if
// output channel: one limited stereo pair per item
// ----------------------------------------------------------------------------
`default_nettype none

interface spl_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic               frame_end_out;
    logic               limiting_active;

    modport source (output valid, output left_out, output right_out,
                    output frame_end_out, output limiting_active, input ready);
    modport sink   (input valid, input left_out, input right_out,
                    input frame_end_out, input limiting_active, output ready);
endinterface

`default_nettype wire

[sv/stereo_peak_limiter_top.sv]
// ----------------------------------------------------------------------------
// stereo_peak_limiter_top
// peak limiter with hold, envelope scaling and make-up gain for stereo pairs
// ----------------------------------------------------------------------------
// usage
//   i_in carries one item per stereo pair (left, right, frame end flag), o_out
//   one result item per pair, both valid/ready; an item moves when both high
//   i_cfg_we/i_cfg_idx/i_cfg_data write the five setup registers; write them
//   only while no item is in flight, the block itself does not enforce this
//   an item is taken in the idle cycle, then the work follows: the single
//   shared multiplier is used three times per channel, for envelope,
//   reciprocal and gain, plus four lane steps; the result is valid on the
//   cycle after the last step, and no new item is taken until then
//   the output register holds a finished result while the sink stalls, and
//   the next item is already taken and worked on; only its final step waits
//   for the output register to free up
//   reset (synchronous, active low) restores the register defaults, clears
//   the envelope, hold counter and phase, and drops any pending result
// ----------------------------------------------------------------------------
`default_nettype none
`include "stereo_peak_limiter_top_macros.svh"

module stereo_peak_limiter_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    spl_in_if.sink           i_in,
    spl_out_if.source        o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);

    spl_pkg::t_cfg w_cfg;     // current register contents
    spl_pkg::t_cmd w_cmd;     // step commands to the datapath

    // setup registers
    spl_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // sequencer: one step per cycle, the last may stall; owns both handshakes
    spl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd)
    );

    // arithmetic, limiter state and output register
    spl_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_cfg             (w_cfg),
        .i_left_in         (i_in.left_in),
        .i_right_in        (i_in.right_in),
        .i_frame_end       (i_in.frame_end),
        .o_left_out        (o_out.left_out),
        .o_right_out       (o_out.right_out),
        .o_frame_end_out   (o_out.frame_end_out),
        .o_limiting_active (o_out.limiting_active)
    );

    // a taken item keeps the block busy on the following cycle
    `SPL_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready)
    // a result is never written over one the sink has not taken
    `SPL_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, w_cmd.load_out, !o_out.valid || o_out.ready)
    // a loaded result is offered on the next cycle
    `SPL_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, w_cmd.load_out, o_out.valid)

endmodule

`default_nettype wire

[sv/spl_cfg.sv]
// ----------------------------------------------------------------------------
// spl_cfg
// configuration register file, write only
// ----------------------------------------------------------------------------
`default_nettype none

module spl_cfg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_idx,
    input  wire logic [15:0]   i_cfg_data,
    output spl_pkg::t_cfg      o_cfg
);

    spl_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.limit_pos       <= spl_pkg::RST_LIMIT_POS;
            r_cfg.limit_neg       <= spl_pkg::RST_LIMIT_NEG;
            r_cfg.envelope_target <= spl_pkg::RST_ENV_TARGET;
            r_cfg.hold_samples    <= spl_pkg::RST_HOLD;
            r_cfg.makeup_gain     <= spl_pkg::RST_MAKEUP_GAIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                spl_pkg::CFG_LIMIT_POS:   r_cfg.limit_pos       <= i_cfg_data[14:0];
                spl_pkg::CFG_LIMIT_NEG:   r_cfg.limit_neg       <= $signed(i_cfg_data);
                spl_pkg::CFG_ENV_TARGET:  r_cfg.envelope_target <= i_cfg_data[6:0];
                spl_pkg::CFG_HOLD:        r_cfg.hold_samples    <= i_cfg_data;
                spl_pkg::CFG_MAKEUP_GAIN: r_cfg.makeup_gain     <= i_cfg_data;
                default: begin
                    // unknown index: write dropped
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[sv/spl_ctrl.sv]
// ----------------------------------------------------------------------------
// spl_ctrl
// step sequencer and output valid flag of the limiter
// ----------------------------------------------------------------------------
`default_nettype none

module spl_ctrl (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output spl_pkg::t_cmd o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_ENV  = 8'b0000_0010,
        S_MAG  = 8'b0000_0100,
        S_REC  = 8'b0000_1000,
        S_FIX  = 8'b0001_0000,
        S_SGN  = 8'b0010_0000,
        S_GAIN = 8'b0100_0000,
        S_SAT  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_ch, n_ch;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_ch        = r_ch;
        o_cmd       = '0;
        o_cmd.op    = spl_pkg::OP_NONE;
        o_cmd.ch    = r_ch;
        o_in_ready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_ch         = 1'b0;
                    n_state      = S_ENV;
                end
            end
            S_ENV: begin
                o_cmd.op = spl_pkg::OP_ENV;
                n_ch     = ~r_ch;
                if (r_ch) n_state = S_MAG;
            end
            S_MAG: begin
                o_cmd.op = spl_pkg::OP_MAG;
                n_state  = S_REC;
            end
            S_REC: begin
                o_cmd.op = spl_pkg::OP_REC;
                n_ch     = ~r_ch;
                if (r_ch) n_state = S_FIX;
            end
            S_FIX: begin
                o_cmd.op = spl_pkg::OP_FIX;
                n_state  = S_SGN;
            end
            S_SGN: begin
                o_cmd.op = spl_pkg::OP_SGN;
                n_state  = S_GAIN;
            end
            S_GAIN: begin
                o_cmd.op = spl_pkg::OP_GAIN;
                n_ch     = ~r_ch;
                if (r_ch) n_state = S_SAT;
            end
            S_SAT: begin
                o_cmd.op = spl_pkg::OP_SAT;
                // wait here while the previous result is still unclaimed
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ch        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ch        <= n_ch;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[sv/spl_dp.sv]
// ----------------------------------------------------------------------------
// spl_dp
// limiter state, shared multiplier and per-channel arithmetic lanes
// ----------------------------------------------------------------------------
`default_nettype none

module spl_dp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire spl_pkg::t_cmd      i_cmd,
    input  wire spl_pkg::t_cfg      i_cfg,
    input  wire logic signed [15:0] i_left_in,
    input  wire logic signed [15:0] i_right_in,
    input  wire logic               i_frame_end,
    output logic signed [15:0]      o_left_out,
    output logic signed [15:0]      o_right_out,
    output logic                    o_frame_end_out,
    output logic                    o_limiting_active
);

    localparam logic [6:0]  ENV_FULL  = 7'd100;
    localparam logic [16:0] RECIP_100 = 17'd41943;   // floor(2^22 / 100)
    localparam int          RECIP_SH  = 22;
    localparam int          GAIN_FRAC = 12;

    typedef enum logic [1:0] {
        PH_STARTUP = 2'd0,
        PH_ATTACK  = 2'd1,
        PH_RELEASE = 2'd2
    } t_phase;

    // limiter state
    t_phase      r_phase, n_phase;
    logic [6:0]  r_env, n_env;
    logic [15:0] r_hold, n_hold;

    // captured item
    logic signed [15:0] r_smp [2];
    logic               r_fe;
    logic               r_active, n_active;

    // lane registers
    logic signed [40:0] r_prod [2];
    logic [21:0]        r_mag  [2];
    logic               r_neg  [2];
    logic [15:0]        r_q    [2];
    logic signed [15:0] r_cur  [2];

    // output register
    logic signed [15:0] r_out_l, r_out_r;
    logic               r_out_fe, r_out_act;

    logic               w_cross;
    logic [15:0]        w_hc;
    t_phase             w_ph_a;
    logic [6:0]         w_env_a;
    logic signed [23:0] w_mul_a;
    logic signed [16:0] w_mul_b;
    logic signed [40:0] w_mul_p;
    logic [21:0]        w_abs  [2];
    logic [15:0]        w_q0   [2];
    logic [21:0]        w_rem  [2];
    logic signed [15:0] w_sat  [2];

    // truncate toward zero after the q4.12 gain, then clamp to 16 bits
    function automatic logic signed [15:0] gain_sat(input logic signed [40:0] p);
        logic signed [40:0] t;
        logic signed [40:0] s;
        t = p + (p[40] ? 41'sd4095 : 41'sd0);
        s = t >>> GAIN_FRAC;
        if (s > 41'sd32767) begin
            gain_sat = 16'sh7fff;
        end else if (s < -41'sd32768) begin
            gain_sat = -16'sh8000;
        end else begin
            gain_sat = s[15:0];
        end
    endfunction

    // state update for the pair being accepted
    always_comb begin
        w_cross = ($signed(i_left_in)  > $signed({1'b0, i_cfg.limit_pos})) ||
                  ($signed(i_left_in)  < i_cfg.limit_neg) ||
                  ($signed(i_right_in) > $signed({1'b0, i_cfg.limit_pos})) ||
                  ($signed(i_right_in) < i_cfg.limit_neg);
        w_hc    = w_cross ? i_cfg.hold_samples : r_hold;
        w_ph_a  = (r_phase == PH_STARTUP) ? PH_ATTACK : r_phase;
        w_env_a = (r_phase == PH_STARTUP) ? ENV_FULL : r_env;
        n_phase = w_ph_a;
        n_env   = w_env_a;
        n_hold  = w_hc;
        n_active = 1'b0;
        if (w_hc != 16'd0) begin
            if (w_ph_a == PH_ATTACK) begin
                if (w_env_a == i_cfg.envelope_target) begin
                    n_phase = PH_RELEASE;
                end else if (w_env_a != 7'd0) begin
                    n_env = w_env_a - 7'd1;
                end
            end
            n_hold   = w_hc - 16'd1;
            n_active = 1'b1;
        end else begin
            n_phase = PH_STARTUP;
            n_env   = r_env;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_STARTUP;
            r_env   <= 7'd0;
            r_hold  <= 16'd0;
        end else if (i_cmd.accept) begin
            r_phase <= n_phase;
            r_env   <= n_env;
            r_hold  <= n_hold;
        end
    end

    // shared multiplier operand selection
    always_comb begin
        unique case (i_cmd.op)
            spl_pkg::OP_ENV: begin
                w_mul_a = 24'(r_smp[i_cmd.ch]);
                w_mul_b = $signed({10'd0, r_env});
            end
            spl_pkg::OP_REC: begin
                w_mul_a = $signed({2'b00, r_mag[i_cmd.ch]});
                w_mul_b = $signed(RECIP_100);
            end
            spl_pkg::OP_GAIN: begin
                w_mul_a = 24'(r_cur[i_cmd.ch]);
                w_mul_b = $signed({1'b0, i_cfg.makeup_gain});
            end
            default: begin
                w_mul_a = 24'sd0;
                w_mul_b = 17'sd0;
            end
        endcase
        w_mul_p = w_mul_a * w_mul_b;
    end

    // lane arithmetic
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            w_abs[i] = r_prod[i][40] ? 22'(-r_prod[i]) : r_prod[i][21:0];
            w_q0[i]  = r_prod[i][RECIP_SH +: 16];
            w_rem[i] = r_mag[i] - ({w_q0[i], 6'd0} + {1'b0, w_q0[i], 5'd0}
                                  + {4'd0, w_q0[i], 2'd0});
            w_sat[i] = gain_sat(r_prod[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_smp[0] <= i_left_in;
            r_smp[1] <= i_right_in;
            r_fe     <= i_frame_end;
            r_active <= n_active;
        end
        unique case (i_cmd.op)
            spl_pkg::OP_ENV, spl_pkg::OP_REC, spl_pkg::OP_GAIN: begin
                r_prod[i_cmd.ch] <= w_mul_p;
            end
            spl_pkg::OP_MAG: begin
                for (int i = 0; i < 2; i++) begin
                    r_neg[i] <= r_prod[i][40];
                    r_mag[i] <= w_abs[i];
                end
            end
            spl_pkg::OP_FIX: begin
                // reciprocal estimate is low by at most one
                for (int i = 0; i < 2; i++) begin
                    r_q[i] <= w_q0[i] + ((w_rem[i] >= 22'd100) ? 16'd1 : 16'd0);
                end
            end
            spl_pkg::OP_SGN: begin
                for (int i = 0; i < 2; i++) begin
                    if (!r_active) begin
                        r_cur[i] <= r_smp[i];
                    end else if (r_neg[i]) begin
                        r_cur[i] <= 16'(-$signed({1'b0, r_q[i]}));
                    end else begin
                        r_cur[i] <= $signed(r_q[i]);
                    end
                end
            end
            default: begin
            end
        endcase
        if (i_cmd.load_out) begin
            r_out_l   <= w_sat[0];
            r_out_r   <= w_sat[1];
            r_out_fe  <= r_fe;
            r_out_act <= r_active;
        end
    end

    assign o_left_out        = r_out_l;
    assign o_right_out       = r_out_r;
    assign o_frame_end_out   = r_out_fe;
    assign o_limiting_active = r_out_act;

endmodule

`default_nettype wire
